>>> sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue: request codes,
// result status codes and the request broadcast to the row of cells.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int OCC_W         = 5;

    // request codes on the mode port
    localparam logic [1:0] MODE_ENQ = 2'd0;
    localparam logic [1:0] MODE_POP = 2'd1;
    localparam logic [1:0] MODE_REM = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_EMPTY    = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_NOTFOUND = 2'd3;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_ENQ,
        CELL_POP,
        CELL_REM_MATCH,
        CELL_REM_SHIFT
    } cell_op_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        cell_op_t                   op;
        logic signed [DATA_W-1:0]   value;
        logic signed [DATA_W-1:0]   prio;
    } spq_req_t;

endpackage

>>> sv/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row. Holds an entry and moves data to or from its
// neighbors for insert, pop and remove.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  spq_pkg::spq_req_t                      req,
    input  logic                                   occupied,
    input  logic signed [spq_pkg::DATA_W-1:0]      prev_value,
    input  logic signed [spq_pkg::DATA_W-1:0]      prev_prio,
    input  logic signed [spq_pkg::DATA_W-1:0]      next_value,
    input  logic signed [spq_pkg::DATA_W-1:0]      next_prio,
    input  logic                                   lower_prev,
    input  logic                                   hit_prev,
    output logic signed [spq_pkg::DATA_W-1:0]      value,
    output logic signed [spq_pkg::DATA_W-1:0]      prio,
    output logic                                   lower,
    output logic                                   hit
);
    import spq_pkg::*;

    logic signed [DATA_W-1:0] value_reg, value_next;
    logic signed [DATA_W-1:0] prio_reg, prio_next;
    logic                     match_reg, match_next;

    // new entry belongs in front of this slot (empty slots count as lower)
    assign lower = !occupied || (req.prio > prio_reg);
    // a match exists at or before this slot
    assign hit   = hit_prev || match_reg;

    always_comb
    begin
        value_next = value_reg;
        prio_next  = prio_reg;
        match_next = match_reg;
        unique case (req.op)
            CELL_ENQ:
            begin
                if (lower_prev)
                begin
                    value_next = prev_value;
                    prio_next  = prev_prio;
                end
                else if (lower)
                begin
                    value_next = req.value;
                    prio_next  = req.prio;
                end
            end
            CELL_POP:
            begin
                value_next = next_value;
                prio_next  = next_prio;
            end
            CELL_REM_MATCH:
            begin
                match_next = occupied && (value_reg == req.value);
            end
            CELL_REM_SHIFT:
            begin
                if (hit)
                begin
                    value_next = next_value;
                    prio_next  = next_prio;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign value = value_reg;
    assign prio  = prio_reg;

endmodule

>>> sv/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Sorted priority queue built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Enqueue, pop and no-op requests complete from idle: busy stays low and a new
// request may be issued every cycle; the result strobe (done) rises in the
// cycle after the request. For remove, the cells first latch their data
// compare, then the first-match chain along the row decides the shift in the
// remove state, with busy high. done is a single-cycle strobe and
// cannot be stalled; popped_value, status and occupancy are valid with it.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [1:0]                             mode,
    input  logic signed [spq_pkg::DATA_W-1:0]      item_value,
    input  logic signed [spq_pkg::DATA_W-1:0]      item_priority,
    output logic                                   done,
    output logic signed [spq_pkg::DATA_W-1:0]      popped_value,
    output logic [1:0]                             status,
    output logic [spq_pkg::OCC_W-1:0]              occupancy
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_REMOVE = 2'b10
    } state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic                     done_reg, done_next;
    logic signed [DATA_W-1:0] popped_reg, popped_next;
    logic [1:0]               status_reg, status_next;
    spq_req_t                 req;

    logic signed [DATA_W-1:0] cell_value [DEPTH];
    logic signed [DATA_W-1:0] cell_prio  [DEPTH];
    logic                     cell_lower [DEPTH];
    logic                     cell_hit   [DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [DATA_W-1:0] pv, pp, nv, np;
            logic                     lp, hp;
            if (gi == 0)
            begin : g_first
                assign pv = cell_value[gi];
                assign pp = cell_prio[gi];
                assign lp = 1'b0;
                assign hp = 1'b0;
            end
            else
            begin : g_mid
                assign pv = cell_value[gi-1];
                assign pp = cell_prio[gi-1];
                assign lp = cell_lower[gi-1];
                assign hp = cell_hit[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign nv = cell_value[gi];
                assign np = cell_prio[gi];
            end
            else
            begin : g_inner
                assign nv = cell_value[gi+1];
                assign np = cell_prio[gi+1];
            end
            spq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .req        (req),
                .occupied   (count_reg > CW'(gi)),
                .prev_value (pv),
                .prev_prio  (pp),
                .next_value (nv),
                .next_prio  (np),
                .lower_prev (lp),
                .hit_prev   (hp),
                .value      (cell_value[gi]),
                .prio       (cell_prio[gi]),
                .lower      (cell_lower[gi]),
                .hit        (cell_hit[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        popped_next = popped_reg;
        status_next = status_reg;
        req.op      = CELL_HOLD;
        req.value   = item_value;
        req.prio    = item_priority;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    popped_next = '0;
                    status_next = STAT_OK;
                    unique case (mode)
                        MODE_ENQ:
                        begin
                            done_next = 1'b1;
                            if (count_reg == CW'(DEPTH))
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                req.op     = CELL_ENQ;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        MODE_POP:
                        begin
                            done_next = 1'b1;
                            if (count_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                req.op      = CELL_POP;
                                popped_next = cell_value[0];
                                count_next  = count_reg - 1'b1;
                            end
                        end
                        MODE_REM:
                        begin
                            req.op     = CELL_REM_MATCH;
                            state_next = ST_REMOVE;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_REMOVE:
            begin
                req.op     = CELL_REM_SHIFT;
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (cell_hit[DEPTH-1])
                begin
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    status_next = STAT_NOTFOUND;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        popped_reg <= popped_next;
        status_reg <= status_next;
    end

    logic [CW+OCC_W-1:0] occ_wide;
    assign occ_wide = {{OCC_W{1'b0}}, count_reg};

    assign busy         = (state_reg == ST_REMOVE);
    assign done         = done_reg;
    assign popped_value = popped_reg;
    assign status       = status_reg;
    assign occupancy    = occ_wide[OCC_W-1:0];

endmodule
